// ----- sv/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge while out of reset
`define AMMS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

// checked on every clock edge, reset included
`define AMMS_ASSERT_ANY(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("assertion failed");

`endif

// ----- sv/amms_pkg.sv -----
// shared types, codes, field layout and mask helpers of the adjacency matrix unit
`default_nettype none
package amms_pkg;

  localparam int MAX_VERTS = 32;
  localparam int VW = $clog2(MAX_VERTS);
  localparam int CW = $clog2(MAX_VERTS + 1);

  typedef logic [MAX_VERTS-1:0] row_t;
  typedef logic [VW-1:0]        vidx_t;
  typedef logic [CW-1:0]        cnt_t;

  // transaction field widths
  localparam int MODE_W = 3;
  localparam int VTX_W  = 5;
  localparam int BITS_W = 32;
  localparam int NCNT_W = 6;
  localparam int STAT_W = 2;
  localparam int OCNT_W = 6;
  localparam int ADD_W  = 5;

  // input tdata layout
  localparam int MODE_LSB = 0;
  localparam int VA_LSB   = MODE_LSB + MODE_W;
  localparam int VB_LSB   = VA_LSB + VTX_W;
  localparam int BITS_LSB = VB_LSB + VTX_W;
  localparam int NCNT_LSB = BITS_LSB + BITS_W;
  localparam int IN_W     = ((NCNT_LSB + NCNT_W + 7) / 8) * 8;

  // output tdata layout
  localparam int STAT_LSB = 0;
  localparam int ROW_LSB  = STAT_LSB + STAT_W;
  localparam int OCNT_LSB = ROW_LSB + BITS_W;
  localparam int ADD_LSB  = OCNT_LSB + OCNT_W;
  localparam int OUT_W    = ((ADD_LSB + ADD_W + 7) / 8) * 8;

  localparam logic [MODE_W-1:0] MODE_LOAD   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SETCNT = 3'd1;
  localparam logic [MODE_W-1:0] MODE_READ   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_IDENT  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CONTR  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_SPLIT  = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EDGE = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd3;

  localparam logic [1:0] CELL_NONE  = 2'd0;
  localparam logic [1:0] CELL_LOAD  = 2'd1;
  localparam logic [1:0] CELL_MERGE = 2'd2;
  localparam logic [1:0] CELL_SPLIT = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    vidx_t      idx;
    vidx_t      keep;
    vidx_t      rem;
    cnt_t       cnt;
    row_t       rvec;
  } cell_cmd_t;

  function automatic row_t low_mask(cnt_t k);
    row_t m;
    for (int j = 0; j < MAX_VERTS; j++) begin
      m[j] = (j < int'(k));
    end
    return m;
  endfunction

  function automatic row_t one_hot(cnt_t k);
    row_t m;
    for (int j = 0; j < MAX_VERTS; j++) begin
      m[j] = (j == int'(k));
    end
    return m;
  endfunction

endpackage
`default_nettype wire

// ----- sv/amms_cell.sv -----
// one matrix row cell: holds and loads a row, merges, shifts from its neighbor, splits
`default_nettype none
module amms_cell (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire amms_pkg::vidx_t    idx_i,
  input  wire amms_pkg::cell_cmd_t cmd_i,
  input  wire amms_pkg::row_t     nb_merged_i,
  output      amms_pkg::row_t     merged_o,
  output      amms_pkg::row_t     row_o
);
  import amms_pkg::*;

  row_t row_q, row_d;
  row_t merged, shifted, colfix, split_row, nmask, seg;
  cnt_t ii, n, kk, rr, aa;

  always_comb begin
    ii    = cnt_t'(idx_i);
    n     = cmd_i.cnt;
    kk    = cnt_t'(cmd_i.keep);
    rr    = cnt_t'(cmd_i.rem);
    aa    = cnt_t'(cmd_i.idx);
    nmask = low_mask(n);

    // merge of the removed vertex into the kept one
    merged = row_q;
    if (ii < n && idx_i != cmd_i.keep && idx_i != cmd_i.rem && cmd_i.rvec[idx_i]) begin
      merged[cmd_i.keep] = 1'b1;
    end
    if (idx_i == cmd_i.keep) begin
      merged = merged | (cmd_i.rvec & nmask & ~one_hot(kk) & ~one_hot(rr));
      if (cmd_i.rvec[cmd_i.rem]) begin
        merged[cmd_i.keep] = 1'b1;
      end
    end

    // row deletion from the upper neighbor
    shifted = merged;
    if (ii >= rr && (ii + cnt_t'(1)) < n) begin
      shifted = (merged & ~nmask) | (nb_merged_i & nmask);
    end

    // column deletion
    seg    = low_mask(n - cnt_t'(1)) & ~low_mask(rr);
    colfix = shifted;
    if ((ii + cnt_t'(1)) < n) begin
      colfix = (shifted & ~seg) | ((shifted >> 1) & seg);
    end

    // split appends vertex n
    split_row = row_q;
    if (ii == n) begin
      split_row = (row_q & ~low_mask(n + cnt_t'(1))) | (cmd_i.rvec & nmask & ~one_hot(aa))
                | one_hot(aa) | (cmd_i.rvec[cmd_i.idx] ? one_hot(n) : '0);
    end else if (ii < n) begin
      split_row[n[VW-1:0]] = (idx_i == cmd_i.idx) ? 1'b1 : cmd_i.rvec[idx_i];
    end

    row_d = row_q;
    case (cmd_i.op)
      CELL_LOAD: begin
        if (idx_i == cmd_i.idx) begin
          row_d = cmd_i.rvec;
        end
      end
      CELL_MERGE: row_d = colfix;
      CELL_SPLIT: row_d = split_row;
      default:    row_d = row_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else begin
      row_q <= row_d;
    end
  end

  assign merged_o = merged;
  assign row_o    = row_q;

endmodule
`default_nettype wire

// ----- sv/amms_ctrl.sv -----
// sequencer: checks, row fetch, cell command, vertex count and output register
`default_nettype none
module amms_ctrl (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       s_tvalid_i,
  output      logic                       s_tready_o,
  input  wire logic [amms_pkg::IN_W-1:0]  s_tdata_i,
  output      logic                       m_tvalid_o,
  input  wire logic                       m_tready_i,
  output      logic [amms_pkg::OUT_W-1:0] m_tdata_o,
  output      amms_pkg::vidx_t            sel_idx_o,
  input  wire amms_pkg::row_t             sel_row_i,
  output      amms_pkg::cell_cmd_t        cmd_o
);
  import amms_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHK   = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  logic [2:0]        state_q, state_d;
  cnt_t              n_q, n_d;
  logic              m_valid_q, m_valid_d;

  logic [MODE_W-1:0] mode_q, mode_d;
  vidx_t             va_q, va_d, vb_q, vb_d, keep_q, keep_d, rem_q, rem_d;
  logic [BITS_W-1:0] bits_q, bits_d, row_out_q, row_out_d;
  logic [NCNT_W-1:0] ncnt_q, ncnt_d;
  row_t              rvec_q, rvec_d;
  logic [1:0]        exec_op_q, exec_op_d;
  logic [STAT_W-1:0] status_q, status_d;
  vidx_t             added_q, added_d;
  logic [OUT_W-1:0]  m_data_q, m_data_d;

  cnt_t va_c, vb_c;
  logic bad_pair;

  always_comb begin
    va_c     = cnt_t'(va_q);
    vb_c     = cnt_t'(vb_q);
    bad_pair = (va_q == vb_q) || (va_c >= n_q) || (vb_c >= n_q);

    state_d   = state_q;
    n_d       = n_q;
    m_valid_d = m_valid_q;
    mode_d    = mode_q;
    va_d      = va_q;
    vb_d      = vb_q;
    bits_d    = bits_q;
    ncnt_d    = ncnt_q;
    keep_d    = keep_q;
    rem_d     = rem_q;
    rvec_d    = rvec_q;
    exec_op_d = exec_op_q;
    status_d  = status_q;
    row_out_d = row_out_q;
    added_d   = added_q;
    m_data_d  = m_data_q;

    if (m_tready_i) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) begin
          mode_d  = s_tdata_i[MODE_LSB +: MODE_W];
          va_d    = s_tdata_i[VA_LSB +: VTX_W];
          vb_d    = s_tdata_i[VB_LSB +: VTX_W];
          bits_d  = s_tdata_i[BITS_LSB +: BITS_W];
          ncnt_d  = s_tdata_i[NCNT_LSB +: NCNT_W];
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        status_d  = ST_OK;
        row_out_d = '0;
        added_d   = '0;
        exec_op_d = CELL_NONE;
        rvec_d    = sel_row_i;
        keep_d    = (va_q < vb_q) ? va_q : vb_q;
        rem_d     = (va_q < vb_q) ? vb_q : va_q;
        state_d   = S_RESP;
        case (mode_q)
          MODE_LOAD: begin
            if (va_c < cnt_t'(MAX_VERTS)) begin
              exec_op_d = CELL_LOAD;
              rvec_d    = row_t'(bits_q);
              state_d   = S_EXEC;
            end else begin
              status_d = ST_BAD;
            end
          end
          MODE_SETCNT: begin
            n_d = (ncnt_q > NCNT_W'(MAX_VERTS)) ? cnt_t'(MAX_VERTS) : cnt_t'(ncnt_q);
          end
          MODE_READ: begin
            if (va_c < cnt_t'(MAX_VERTS)) begin
              row_out_d = BITS_W'(sel_row_i);
            end else begin
              status_d = ST_BAD;
            end
          end
          MODE_IDENT, MODE_CONTR: begin
            if (bad_pair) begin
              status_d = ST_BAD;
            end else if (mode_q == MODE_CONTR && !sel_row_i[vb_q]) begin
              status_d = ST_EDGE;
            end else begin
              exec_op_d = CELL_MERGE;
              state_d   = S_FETCH;
            end
          end
          MODE_SPLIT: begin
            if (va_c >= n_q) begin
              status_d = ST_BAD;
            end else if (n_q >= cnt_t'(MAX_VERTS)) begin
              status_d = ST_FULL;
            end else begin
              exec_op_d = CELL_SPLIT;
              added_d   = n_q[VW-1:0];
              state_d   = S_EXEC;
            end
          end
          default: begin
            status_d = ST_OK;
          end
        endcase
      end
      S_FETCH: begin
        rvec_d  = sel_row_i;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        if (exec_op_q == CELL_MERGE) begin
          n_d = n_q - cnt_t'(1);
        end else if (exec_op_q == CELL_SPLIT) begin
          n_d = n_q + cnt_t'(1);
        end
        state_d = S_RESP;
      end
      S_RESP: begin
        if (!m_valid_q || m_tready_i) begin
          m_valid_d                       = 1'b1;
          m_data_d                        = '0;
          m_data_d[STAT_LSB +: STAT_W]    = status_q;
          m_data_d[ROW_LSB +: BITS_W]     = row_out_q;
          m_data_d[OCNT_LSB +: OCNT_W]    = OCNT_W'(n_q);
          m_data_d[ADD_LSB +: ADD_W]      = ADD_W'(added_q);
          state_d                         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      n_q       <= '0;
      m_valid_q <= 1'b0;
      exec_op_q <= CELL_NONE;
    end else begin
      state_q   <= state_d;
      n_q       <= n_d;
      m_valid_q <= m_valid_d;
      exec_op_q <= exec_op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q    <= mode_d;
    va_q      <= va_d;
    vb_q      <= vb_d;
    bits_q    <= bits_d;
    ncnt_q    <= ncnt_d;
    keep_q    <= keep_d;
    rem_q     <= rem_d;
    rvec_q    <= rvec_d;
    status_q  <= status_d;
    row_out_q <= row_out_d;
    added_q   <= added_d;
    m_data_q  <= m_data_d;
  end

  assign s_tready_o = (state_q == S_IDLE);
  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;
  assign sel_idx_o  = (state_q == S_FETCH) ? rem_q : va_q;

  always_comb begin
    cmd_o      = '0;
    cmd_o.op   = (state_q == S_EXEC) ? exec_op_q : CELL_NONE;
    cmd_o.idx  = va_q;
    cmd_o.keep = keep_q;
    cmd_o.rem  = rem_q;
    cmd_o.cnt  = n_q;
    cmd_o.rvec = rvec_q;
  end

endmodule
`default_nettype wire

// ----- sv/adjacency_matrix_merge_split_unit.sv -----
// top level of the adjacency matrix merge and split unit
// The unit keeps a 32 x 32 bit adjacency matrix in a row of cells, one row per cell,
// and takes one transaction at a time. Between acceptances the sequencer checks
// the operands, fetches the rows it needs through a single row-select port, and
// all cells then apply the merge, row and column deletion or split together, each
// cell taking the row shift from its upper neighbor. A new transaction is taken
// while the previous result still waits in the output register; a result waits
// for that register to empty. Matrix and vertex count are cleared at reset.
`default_nettype none
module adjacency_matrix_merge_split_unit (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       s_axis_tvalid_i,
  output      logic                       s_axis_tready_o,
  // mode[2:0] vertex_a[7:3] vertex_b[12:8] row_bits[44:13] new_count[50:45]
  input  wire logic [amms_pkg::IN_W-1:0]  s_axis_tdata_i,
  output      logic                       m_axis_tvalid_o,
  input  wire logic                       m_axis_tready_i,
  // status[1:0] row_out[33:2] vertex_count[39:34] added_vertex[44:40]
  output      logic [amms_pkg::OUT_W-1:0] m_axis_tdata_o
);
  import amms_pkg::*;

  cell_cmd_t cmd;
  vidx_t     sel_idx;
  row_t      sel_row;
  row_t      rows   [MAX_VERTS];
  row_t      merged [MAX_VERTS+1];

  amms_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .s_tdata_i  (s_axis_tdata_i),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (m_axis_tdata_o),
    .sel_idx_o  (sel_idx),
    .sel_row_i  (sel_row),
    .cmd_o      (cmd)
  );

  assign merged[MAX_VERTS] = '0;

  for (genvar g = 0; g < MAX_VERTS; g++) begin : g_cell
    amms_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .idx_i       (vidx_t'(g)),
      .cmd_i       (cmd),
      .nb_merged_i (merged[g+1]),
      .merged_o    (merged[g]),
      .row_o       (rows[g])
    );
  end

  assign sel_row = rows[sel_idx];

endmodule
`default_nettype wire

// ----- sv/amms_checker.sv -----
// port-level checker for the adjacency matrix unit and its bind
`default_nettype none
`include "assert_macros.svh"
module amms_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       s_axis_tvalid_i,
  input wire logic                       s_axis_tready_o,
  input wire logic [amms_pkg::IN_W-1:0]  s_axis_tdata_i,
  input wire logic                       m_axis_tvalid_o,
  input wire logic                       m_axis_tready_i,
  input wire logic [amms_pkg::OUT_W-1:0] m_axis_tdata_o
);
  import amms_pkg::*;

  logic [STAT_W-1:0] st;
  logic [BITS_W-1:0] rw;
  logic [OCNT_W-1:0] vc;
  logic [ADD_W-1:0]  av;

  assign st = m_axis_tdata_o[STAT_LSB +: STAT_W];
  assign rw = m_axis_tdata_o[ROW_LSB +: BITS_W];
  assign vc = m_axis_tdata_o[OCNT_LSB +: OCNT_W];
  assign av = m_axis_tdata_o[ADD_LSB +: ADD_W];

  `AMMS_ASSERT_ANY(a_rst_quiet, !rst_ni |=> !m_axis_tvalid_o)
  `AMMS_ASSERT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
  `AMMS_ASSERT(a_count_max, m_axis_tvalid_o |-> vc <= OCNT_W'(MAX_VERTS))
  `AMMS_ASSERT(a_added_ok, m_axis_tvalid_o && av != '0 |-> st == ST_OK && rw == '0)
  `AMMS_ASSERT(a_row_ok, m_axis_tvalid_o && rw != '0 |-> st == ST_OK)

endmodule

bind adjacency_matrix_merge_split_unit amms_checker u_amms_checker (.*);
`default_nettype wire
